[rtl/mstb_pkg.sv]
`timescale 1ns / 1ps
package mstb_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_REF   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_KIND   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FINAL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic walk_end;
  } stat_t;

endpackage

[rtl/multi_slot_timer_bank.sv]
`timescale 1ns / 1ps
// Set, clear and reference words: one result, in the cycle after the execute state.
// Tick words: the walk checks one slot per cycle through the single slot-store
// read port, and each expiry is registered in the cycle after its check.
// A new word is taken once busy drops; the receiver cannot stall results.
// Synchronous reset frees every slot and returns the controller to idle.
module multi_slot_timer_bank
  import mstb_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] now_time,
  input  logic [31:0] period,
  input  logic        one_shot,
  input  logic [4:0]  slot_id,
  input  logic        ref_on,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [4:0]  result_id,
  output logic        expired,
  output logic        keep_alive,
  output logic        last
);

  cmd_t  cmd;
  stat_t stat;

  mstb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mstb_dp #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .now_time     (now_time),
    .period       (period),
    .one_shot     (one_shot),
    .slot_id      (slot_id),
    .ref_on       (ref_on),
    .result_valid (result_valid),
    .status       (status),
    .result_id    (result_id),
    .expired      (expired),
    .keep_alive   (keep_alive),
    .last         (last)
  );

endmodule

[rtl/mstb_ctrl.sv]
`timescale 1ns / 1ps
module mstb_ctrl
  import mstb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // advance sequence and issue commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_tick) begin
          state_next = S_WALK;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (stat.walk_end) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/mstb_dp.sv]
`timescale 1ns / 1ps
module mstb_dp
  import mstb_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  operation,
  input  logic [31:0] now_time,
  input  logic [31:0] period,
  input  logic        one_shot,
  input  logic [4:0]  slot_id,
  input  logic        ref_on,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [4:0]  result_id,
  output logic        expired,
  output logic        keep_alive,
  output logic        last
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int T  = TIME_BITS;

  // captured word
  op_t          op_r;
  logic [T-1:0] now_r;
  logic [T-1:0] per_r;
  logic         once_r;
  logic [4:0]   id_r;
  logic         ref_r;

  // slot store
  logic [SLOTS-1:0] live;
  logic [SLOTS-1:0] once;
  logic [SLOTS-1:0] unref;
  logic [SLOTS-1:0] started;
  logic [T-1:0]     prev_mem [SLOTS];
  logic [T-1:0]     dl_mem   [SLOTS];
  logic [T-1:0]     per_mem  [SLOTS];

  logic [AW-1:0] k;
  logic          keep;

  // lowest free slot
  logic          full;
  logic [AW-1:0] low_slot;
  always_comb begin
    full     = 1'b1;
    low_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        full     = 1'b0;
        low_slot = AW'(i);
      end
    end
  end

  // decode the id of a clear or reference word
  logic          id_ok;
  logic [AW-1:0] id_idx;
  logic [5:0]    id_m1;
  assign id_m1  = {1'b0, id_r} - 6'd1;
  assign id_idx = AW'(id_m1);
  assign id_ok  = (id_r != 5'd0) && (6'(id_r) <= 6'(SLOTS)) && live[id_idx];

  // deadline test for the walked slot
  logic [T-1:0] p_k, d_k;
  logic         wait_k, fire_k;
  assign p_k = prev_mem[k];
  assign d_k = dl_mem[k];
  always_comb begin
    if (p_k <= d_k) begin
      wait_k = (p_k <= now_r) && (now_r < d_k);
    end else begin
      wait_k = (now_r < d_k) || (p_k <= now_r);
    end
    fire_k = live[k] && started[k] && !wait_k;
  end

  assign stat.is_tick  = (op_r == OP_TICK);
  assign stat.walk_end = (k == AW'(SLOTS - 1));

  // capture word, walk index and keep-alive
  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= '0;
      keep <= 1'b0;
    end else if (cmd.load) begin
      k    <= '0;
      keep <= 1'b0;
    end else if (cmd.step) begin
      k <= k + AW'(1);
      if (live[k] && !unref[k]) begin
        keep <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(operation);
      now_r  <= T'(now_time);
      per_r  <= T'(period);
      once_r <= one_shot;
      id_r   <= slot_id;
      ref_r  <= ref_on;
    end
  end

  // update slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (cmd.exec) begin
      unique case (op_r)
        OP_SET: begin
          if (!full) begin
            live[low_slot] <= 1'b1;
          end
        end
        OP_CLEAR: begin
          if (id_ok && once[id_idx] == once_r) begin
            live[id_idx] <= 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd.step) begin
      if (fire_k && once[k]) begin
        live[k] <= 1'b0;
      end
    end
  end

  // update slot payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (op_r == OP_SET && !full) begin
        once[low_slot]     <= once_r;
        unref[low_slot]    <= 1'b0;
        started[low_slot]  <= 1'b0;
        prev_mem[low_slot] <= now_r;
        dl_mem[low_slot]   <= now_r + per_r;
        per_mem[low_slot]  <= per_r;
      end else if (op_r == OP_REF && id_ok) begin
        unref[id_idx] <= !ref_r;
      end
    end else if (cmd.step && live[k]) begin
      if (!started[k]) begin
        started[k] <= 1'b1;
      end else if (fire_k && !once[k]) begin
        prev_mem[k] <= d_k;
        dl_mem[k]   <= d_k + per_mem[k];
      end
    end
  end

  // drive result word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.exec || cmd.fin || (cmd.step && fire_k);
    end
  end

  always_ff @(posedge clk) begin
    status     <= ST_OK;
    result_id  <= 5'd0;
    expired    <= 1'b0;
    keep_alive <= 1'b0;
    last       <= 1'b1;
    if (cmd.exec) begin
      unique case (op_r)
        OP_SET: begin
          if (full) begin
            status <= ST_FULL;
          end else begin
            result_id <= 5'(low_slot) + 5'd1;
          end
        end
        OP_CLEAR: begin
          if (!id_ok) begin
            status <= ST_BAD_ID;
          end else if (once[id_idx] != once_r) begin
            status <= ST_KIND;
          end
        end
        default: begin
          if (!id_ok) begin
            status <= ST_BAD_ID;
          end
        end
      endcase
    end else if (cmd.step) begin
      result_id <= 5'(k) + 5'd1;
      expired   <= 1'b1;
      last      <= 1'b0;
    end else if (cmd.fin) begin
      keep_alive <= keep;
    end
  end

endmodule

[rtl/mstb_checker.sv]
`timescale 1ns / 1ps
module mstb_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic [1:0] status,
  input logic [4:0] result_id,
  input logic       expired,
  input logic       keep_alive,
  input logic       last
);

  // accepted word makes the bank busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy did not rise after start");

  // every result that is not final reports an expiry
  a_mid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> expired) else $error("non-final result without expiry");

  // expiry carries ok status and a real id
  a_exp: assert property (@(posedge clk) disable iff (rst)
    result_valid && expired |-> status == 2'd0 && result_id != 5'd0 && !keep_alive)
    else $error("bad expiry result");

  // keep-alive only on a final result
  a_ka: assert property (@(posedge clk) disable iff (rst)
    result_valid && keep_alive |-> last && !expired) else $error("keep-alive misplaced");

endmodule

bind multi_slot_timer_bank mstb_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .status       (status),
  .result_id    (result_id),
  .expired      (expired),
  .keep_alive   (keep_alive),
  .last         (last)
);
